// ===== design/cau_pkg.sv =====
// cau_pkg: opcodes shared by the complex arithmetic unit
package cau_pkg;

	// operation codes carried in the low bits of the input item
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NEG = 3'd4,
		OP_EQ  = 3'd5
	} op_t;

	localparam int unsigned OP_BITS = 3;

endpackage

// ===== design/cau_div.sv =====
// cau_div: pipelined restoring divider for two numerators over one shared divisor
module cau_div #(
	parameter int unsigned W  = 32,
	parameter int unsigned F  = 16,
	parameter int unsigned SW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2*W+F-1:0]     in_x_re,
	input  logic [2*W+F-1:0]     in_x_im,
	input  logic [2*W-1:0]       in_den,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic [W-1:0]         out_q_re,
	output logic [W-1:0]         out_q_im,
	output logic [SW-1:0]        out_side
);

	localparam int unsigned RW = 3*W + F;

	logic          vld  [0:W];
	logic [RW-1:0] rre  [0:W];
	logic [RW-1:0] rim  [0:W];
	logic [2*W-1:0] dn  [0:W];
	logic [W-1:0]  qre  [0:W];
	logic [W-1:0]  qim  [0:W];
	logic [SW-1:0] sd   [0:W];

	// stage zero is the input itself
	assign vld[0] = in_valid;
	assign rre[0] = RW'(in_x_re);
	assign rim[0] = RW'(in_x_im);
	assign dn[0]  = in_den;
	assign qre[0] = '0;
	assign qim[0] = '0;
	assign sd[0]  = in_side;

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [RW-1:0] dsh;
		logic          ge_re, ge_im;
		logic [W-1:0]  nq_re, nq_im;

		always_comb begin
			dsh   = RW'(dn[k]) << (W - 1 - k);
			ge_re = rre[k] >= dsh;
			ge_im = rim[k] >= dsh;
			nq_re = qre[k];
			nq_im = qim[k];
			nq_re[W-1-k] = ge_re;
			nq_im[W-1-k] = ge_im;
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				rre[k+1] <= ge_re ? (rre[k] - dsh) : rre[k];
				rim[k+1] <= ge_im ? (rim[k] - dsh) : rim[k];
				dn[k+1]  <= dn[k];
				qre[k+1] <= nq_re;
				qim[k+1] <= nq_im;
				sd[k+1]  <= sd[k];
			end
		end
	end

	assign out_valid = vld[W];
	assign out_q_re  = qre[W];
	assign out_q_im  = qim[W];
	assign out_side  = sd[W];

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// complex_arithmetic_unit: pipelined complex add, subtract, multiply, divide, negate, compare
//
// Items arrive on the s_ stream: op, a_re, a_im, b_re, b_im packed in s_tdata.
// Results leave on the m_ stream: res_re, res_im, is_equal, div_zero, overflow.
// Every item yields one result, in order, whatever the operation.
// Every item passes one product stage, one sum stage, one magnitude stage, one
// stage per quotient bit of the divider, and the output register. All operations
// share that path, so order is kept. Throughput is one item per cycle while the
// pipeline is not held; the six operand multipliers and the chain of DATA_WIDTH
// compare-subtract stages each take a new item every cycle.
// When m_tready is low while a result waits, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. Reset clears all valid bits;
// s_tready is high right after reset. Results out of range saturate and raise
// overflow; a zero divisor gives zero parts and raises div_zero.
module complex_arithmetic_unit #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// op, a_re, a_im, b_re, b_im from bit 0 up, zero padded
	input  logic [((cau_pkg::OP_BITS + 4*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// res_re, res_im, is_equal, div_zero, overflow from bit 0 up, zero padded
	output logic [((2*DATA_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int unsigned W   = DATA_WIDTH;
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned OB  = cau_pkg::OP_BITS;
	localparam int unsigned XW  = 2*W + F;
	localparam int unsigned RW  = 3*W + F;
	localparam int unsigned OUT_BW = ((2*W + 3 + 7) / 8) * 8;

	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [2*W-1:0] HALF = (2*W)'(1) << (W - 1);

	typedef struct packed {
		logic [W-1:0] re;
		logic [W-1:0] im;
		logic         eq;
		logic         dz;
		logic         ovf;
		logic         is_div;
		logic         neg_re;
		logic         neg_im;
		logic         big_re;
		logic         big_im;
	} side_t;

	localparam int unsigned SW = $bits(side_t);

	// sign-magnitude to saturated two's complement, overflow flag on top
	function automatic logic [W:0] sat_sm(input logic neg, input logic [2*W-1:0] mag);
		logic [W:0] r;
		if (!neg && mag >= HALF) begin
			r = {1'b1, VMAX};
		end else if (neg && mag > HALF) begin
			r = {1'b1, VMIN};
		end else if (neg) begin
			r = {1'b0, ~mag[W-1:0] + W'(1)};
		end else begin
			r = {1'b0, mag[W-1:0]};
		end
		return r;
	endfunction

	// saturate a two's complement sum that is one bit wider than the result
	function automatic logic [W:0] sat_tc(input logic [W:0] s);
		logic [W:0] r;
		if (s[W] != s[W-1]) begin
			r = {1'b1, (s[W] ? VMIN : VMAX)};
		end else begin
			r = {1'b0, s[W-1:0]};
		end
		return r;
	endfunction

	logic en;
	logic out_valid_d;
	logic [W-1:0] q_re_d, q_im_d;
	logic [SW-1:0] side_d;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input fields
	logic [OB-1:0]       op_in;
	logic signed [W-1:0] ar, ai, br, bi;

	assign op_in = s_tdata[OB-1:0];
	assign ar    = s_tdata[OB +: W];
	assign ai    = s_tdata[OB + W +: W];
	assign br    = s_tdata[OB + 2*W +: W];
	assign bi    = s_tdata[OB + 3*W +: W];

	// stage 1: products, simple sums, equality
	logic                  v_s1;
	logic [OB-1:0]         op_s1;
	logic signed [2*W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;
	logic [W:0]            as_s1;
	logic                  eq_s1;
	logic [W:0]            as_d;

	always_comb begin
		unique case (cau_pkg::op_t'(op_in))
			cau_pkg::OP_ADD: as_d = {ar[W-1], ar} + {br[W-1], br};
			cau_pkg::OP_SUB: as_d = {ar[W-1], ar} - {br[W-1], br};
			cau_pkg::OP_NEG: as_d = ~{ar[W-1], ar} + (W+1)'(1);
			default:         as_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op_in;
			p_rr_s1 <= ar * br;
			p_ii_s1 <= ai * bi;
			p_ri_s1 <= ar * bi;
			p_ir_s1 <= ai * br;
			p_bb_s1 <= br * br;
			p_cc_s1 <= bi * bi;
			as_s1   <= as_d;
			eq_s1   <= (ar == br) && (ai == bi);
		end
	end

	// stage 2: sums of products, divisor sum, simple-result saturation
	logic                  v_s2;
	logic [OB-1:0]         op_s2;
	logic [2*W:0]          mre_s2, mim_s2, nre_s2, nim_s2;
	logic [2*W-1:0]        den_s2;
	logic [W:0]            simple_s2;
	logic [W:0]            simple_im_unused;
	logic                  eq_s2;
	logic [2*W:0]          den_sum;

	assign den_sum = {p_bb_s1[2*W-1], p_bb_s1} + {p_cc_s1[2*W-1], p_cc_s1};
	assign simple_im_unused = '0;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2     <= op_s1;
			mre_s2    <= {p_rr_s1[2*W-1], p_rr_s1} - {p_ii_s1[2*W-1], p_ii_s1};
			mim_s2    <= {p_ri_s1[2*W-1], p_ri_s1} + {p_ir_s1[2*W-1], p_ir_s1};
			nre_s2    <= {p_rr_s1[2*W-1], p_rr_s1} + {p_ii_s1[2*W-1], p_ii_s1};
			nim_s2    <= {p_ir_s1[2*W-1], p_ir_s1} - {p_ri_s1[2*W-1], p_ri_s1};
			den_s2    <= den_sum[2*W-1:0];
			simple_s2 <= sat_tc(as_s1) | simple_im_unused;
			eq_s2     <= eq_s1;
		end
	end

	// the imaginary simple result is the same form as the real one
	logic [W:0] as_im_s1, simple_im_s2, as_im_d;

	always_comb begin
		logic signed [W-1:0] ai_v, bi_v;
		ai_v = ai;
		bi_v = bi;
		unique case (cau_pkg::op_t'(op_in))
			cau_pkg::OP_ADD: as_im_d = {ai_v[W-1], ai_v} + {bi_v[W-1], bi_v};
			cau_pkg::OP_SUB: as_im_d = {ai_v[W-1], ai_v} - {bi_v[W-1], bi_v};
			cau_pkg::OP_NEG: as_im_d = ~{ai_v[W-1], ai_v} + (W+1)'(1);
			default:         as_im_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			as_im_s1     <= as_im_d;
			simple_im_s2 <= sat_tc(as_im_s1);
		end
	end

	// stage 3: magnitudes, multiply saturation, divider set-up
	logic                 v_s3;
	logic [XW-1:0]        x_re_s3, x_im_s3;
	logic [2*W-1:0]       den_s3;
	side_t                side_s3;

	logic [2*W:0]   mag_mre, mag_mim, mag_nre, mag_nim;
	logic [2*W-1:0] sh_mre, sh_mim;
	logic [XW-1:0]  x_re_d, x_im_d;
	logic [W:0]     sm_re, sm_im;
	logic           big_re_d, big_im_d;
	side_t          side_d3;

	always_comb begin
		mag_mre = mre_s2[2*W] ? (~mre_s2 + (2*W+1)'(1)) : mre_s2;
		mag_mim = mim_s2[2*W] ? (~mim_s2 + (2*W+1)'(1)) : mim_s2;
		mag_nre = nre_s2[2*W] ? (~nre_s2 + (2*W+1)'(1)) : nre_s2;
		mag_nim = nim_s2[2*W] ? (~nim_s2 + (2*W+1)'(1)) : nim_s2;
		sh_mre  = mag_mre[2*W-1:0] >> F;
		sh_mim  = mag_mim[2*W-1:0] >> F;
		sm_re   = sat_sm(mre_s2[2*W], sh_mre);
		sm_im   = sat_sm(mim_s2[2*W], sh_mim);
		x_re_d  = XW'(mag_nre[2*W-1:0]) << F;
		x_im_d  = XW'(mag_nim[2*W-1:0]) << F;
		big_re_d = RW'(x_re_d) >= (RW'(den_s2) << W);
		big_im_d = RW'(x_im_d) >= (RW'(den_s2) << W);

		side_d3        = '0;
		side_d3.neg_re = nre_s2[2*W];
		side_d3.neg_im = nim_s2[2*W];
		side_d3.big_re = big_re_d;
		side_d3.big_im = big_im_d;
		unique case (cau_pkg::op_t'(op_s2))
			cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG: begin
				side_d3.re  = simple_s2[W-1:0];
				side_d3.im  = simple_im_s2[W-1:0];
				side_d3.ovf = simple_s2[W] | simple_im_s2[W];
			end
			cau_pkg::OP_MUL: begin
				side_d3.re  = sm_re[W-1:0];
				side_d3.im  = sm_im[W-1:0];
				side_d3.ovf = sm_re[W] | sm_im[W];
			end
			cau_pkg::OP_DIV: begin
				side_d3.dz     = (den_s2 == '0);
				side_d3.is_div = (den_s2 != '0);
			end
			cau_pkg::OP_EQ: begin
				side_d3.eq = eq_s2;
			end
			default: begin
				side_d3.ovf = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_re_s3 <= x_re_d;
			x_im_s3 <= x_im_d;
			den_s3  <= den_s2;
			side_s3 <= side_d3;
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// quotient bits, one stage each
	cau_div #(
		.W  (W),
		.F  (F),
		.SW (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_x_re   (x_re_s3),
		.in_x_im   (x_im_s3),
		.in_den    (den_s3),
		.in_side   (side_s3),
		.out_valid (out_valid_d),
		.out_q_re  (q_re_d),
		.out_q_im  (q_im_d),
		.out_side  (side_d)
	);

	// output register: quotient saturation and item packing
	side_t      sd;
	logic [W:0] dq_re, dq_im;
	logic [OUT_BW-1:0] data_d;

	always_comb begin
		sd    = side_t'(side_d);
		dq_re = sat_sm(sd.neg_re, sd.big_re ? '1 : (2*W)'(q_re_d));
		dq_im = sat_sm(sd.neg_im, sd.big_im ? '1 : (2*W)'(q_im_d));
		data_d = '0;
		if (sd.is_div) begin
			data_d[W-1:0]   = dq_re[W-1:0];
			data_d[2*W-1:W] = dq_im[W-1:0];
			data_d[2*W+2]   = dq_re[W] | dq_im[W];
		end else begin
			data_d[W-1:0]   = sd.re;
			data_d[2*W-1:W] = sd.im;
			data_d[2*W+2]   = sd.ovf;
		end
		data_d[2*W]   = sd.eq;
		data_d[2*W+1] = sd.dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= data_d;
		end
	end

endmodule
